// ===== hdl/per_core_page_allocator_with_steal_unit_defines.svh =====
`ifndef PER_CORE_PAGE_ALLOCATOR_WITH_STEAL_UNIT_DEFINES_SVH
`define PER_CORE_PAGE_ALLOCATOR_WITH_STEAL_UNIT_DEFINES_SVH

// same-cycle implication
`define PCPA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCPA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pcpa_pkg.sv =====
`default_nettype none
package pcpa_pkg;

  localparam int NUM_CORES_DEF  = 8;
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W      = 32;
  localparam int CORE_FW     = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 1'b1;

  localparam logic [ADDR_W-1:0] LOWEST_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RST    = 32'h8800_0000;

  typedef struct packed {
    logic push;
    logic pop;
  } head_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/pcpa_ram.sv =====
`default_nettype none
module pcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pcpa_chk.sv =====
`default_nettype none
module pcpa_chk
  import pcpa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic [ADDR_W-1:0]            addr,
  input  wire logic [ADDR_W-1:0]            lowest,
  input  wire logic [ADDR_W-1:0]            top,
  input  wire logic [ADDR_W:0]              base,
  output      logic                         bad,
  output      logic [$clog2(NUM_PAGES)-1:0] idx
);

  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int IDX_W   = $clog2(NUM_PAGES);

  logic [ADDR_W:0] diff;
  logic [ADDR_W:0] pidx;

  always_comb begin
    diff = {1'b0, addr} - base;
    pidx = diff >> PAGE_SH;
    bad  = (|addr[PAGE_SH-1:0]) || (addr < lowest) || (addr >= top) ||
           ({1'b0, addr} < base) || (pidx >= (ADDR_W+1)'(NUM_PAGES));
    idx  = pidx[IDX_W-1:0];
  end

endmodule
`default_nettype wire

// ===== hdl/pcpa_heads.sv =====
`default_nettype none
module pcpa_heads
  import pcpa_pkg::*;
#(
  parameter int NUM_CORES = NUM_CORES_DEF,
  parameter int HEAD_W    = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire head_ctl_t                                  ctl,
  input  wire logic [(NUM_CORES > 1 ? $clog2(NUM_CORES) : 1)-1:0] req_core,
  input  wire logic [HEAD_W-1:0]                          push_val,
  input  wire logic [HEAD_W-1:0]                          pop_val,
  output      logic [HEAD_W-1:0]                          own_head,
  output      logic [HEAD_W-1:0]                          sel_head,
  output      logic                                       sel_any
);

  localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  logic [HEAD_W-1:0] head_r [NUM_CORES];
  logic [CORE_W-1:0] steal_core;
  logic              steal_any;
  logic [CORE_W-1:0] sel_core;

  always_comb begin
    steal_core = '0;
    steal_any  = 1'b0;
    for (int c = NUM_CORES - 1; c >= 0; c--) begin
      if (head_r[c] != '0 && CORE_W'(c) != req_core) begin
        steal_core = CORE_W'(c);
        steal_any  = 1'b1;
      end
    end
    own_head = head_r[req_core];
    if (own_head != '0) begin
      sel_core = req_core;
      sel_any  = 1'b1;
    end else begin
      sel_core = steal_core;
      sel_any  = steal_any;
    end
    sel_head = head_r[sel_core];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        head_r[c] <= '0;
      end
    end else if (ctl.push) begin
      head_r[req_core] <= push_val;
    end else if (ctl.pop) begin
      head_r[sel_core] <= pop_val;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/per_core_page_allocator_with_steal_unit.sv =====
// Channel  Ports                       Contents
// in       in_tvalid/in_tready         tuser: action; tdata: core, free_addr
// out      out_tvalid/out_tready       tdata: page_addr, status
// cfg      cfg_valid/cfg_ready         cfg_index, cfg_data (always ready)
//
// A free: accept, then check, link write and head update.
// An allocate that finds a page reads the next link from the
// link RAM (a registered read) before the head is updated.
// An allocate that finds no page skips the link read.
// Reset is synchronous; heads clear at once, the link RAM is not cleared.
// A full output register holds the request in its last step until taken.
`default_nettype none
`include "per_core_page_allocator_with_steal_unit_defines.svh"
module per_core_page_allocator_with_steal_unit
  import pcpa_pkg::*;
#(
  parameter int NUM_CORES  = NUM_CORES_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] core, [34:3] free_addr
  input  wire logic                   in_tuser,   // [0] action
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] page_addr, [33:32] status
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data
);

  localparam int CORE_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int HEAD_W  = $clog2(NUM_PAGES + 1);
  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int OFF_W   = HEAD_W + PAGE_SH;
  localparam int SUM_W   = (OFF_W > ADDR_W) ? OFF_W : ADDR_W;
  localparam int FOLD_W  = ($clog2(NUM_CORES + 1) > CORE_FW) ?
                           $clog2(NUM_CORES + 1) : CORE_FW + 1;
  localparam logic [ADDR_W:0] PAGE_MASK = ~((ADDR_W+1)'(PAGE_BYTES - 1));
  localparam logic [ADDR_W:0] BASE_RST  =
    ({1'b0, LOWEST_RST} + (ADDR_W+1)'(PAGE_BYTES - 1)) & PAGE_MASK;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP} state_t;

  function automatic logic [CORE_W-1:0] core_fold(input logic [CORE_FW-1:0] c);
    logic [FOLD_W-1:0] v;
    v = FOLD_W'(c);
    for (int i = 0; i < 8; i++) begin
      if (v >= FOLD_W'(NUM_CORES)) begin
        v = v - FOLD_W'(NUM_CORES);
      end
    end
    return v[CORE_W-1:0];
  endfunction

  state_t              state_r;
  logic                req_act_r;
  logic [CORE_W-1:0]   req_core_r;
  logic [ADDR_W-1:0]   req_addr_r;
  logic [ADDR_W-1:0]   lowest_r;
  logic [ADDR_W-1:0]   top_r;
  logic [ADDR_W:0]     base_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                out_free;
  logic                out_load;
  logic                chk_bad;
  logic [IDX_W-1:0]    chk_idx;
  head_ctl_t           hctl;
  logic [HEAD_W-1:0]   own_head;
  logic [HEAD_W-1:0]   sel_head;
  logic                sel_any;
  logic [HEAD_W-1:0]   push_val;
  logic [HEAD_W-1:0]   head_m1;
  logic [HEAD_W-1:0]   link_rdata;
  logic                ram_we;
  logic                ram_re;
  logic [OFF_W-1:0]    pop_off;
  logic [SUM_W-1:0]    pop_off_ext;
  logic [ADDR_W-1:0]   pop_addr;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - STATUS_W){1'b0}}, out_status_r, out_addr_r};
  assign out_free   = !out_valid_r || out_tready;

  pcpa_chk #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_chk (
    .addr  (req_addr_r),
    .lowest(lowest_r),
    .top   (top_r),
    .base  (base_r),
    .bad   (chk_bad),
    .idx   (chk_idx)
  );

  pcpa_heads #(
    .NUM_CORES(NUM_CORES),
    .HEAD_W   (HEAD_W)
  ) u_heads (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (hctl),
    .req_core(req_core_r),
    .push_val(push_val),
    .pop_val (link_rdata),
    .own_head(own_head),
    .sel_head(sel_head),
    .sel_any (sel_any)
  );

  pcpa_ram #(
    .WIDTH(HEAD_W),
    .DEPTH(NUM_PAGES)
  ) u_link_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (chk_idx),
    .wdata  (own_head),
    .re     (ram_re),
    .raddr  (head_m1[IDX_W-1:0]),
    .rdata_r(link_rdata)
  );

  always_comb begin
    push_val    = HEAD_W'(chk_idx) + HEAD_W'(1);
    head_m1     = sel_head - HEAD_W'(1);
    pop_off     = {head_m1, {PAGE_SH{1'b0}}};
    pop_off_ext = SUM_W'(pop_off);
    pop_addr    = base_r[ADDR_W-1:0] + pop_off_ext[ADDR_W-1:0];
    ram_we      = (state_r == S_EXEC) && (req_act_r == ACT_FREE) && out_free && !chk_bad;
    ram_re      = (state_r == S_EXEC) && (req_act_r == ACT_ALLOC) && sel_any;
    hctl.push   = ram_we;
    hctl.pop    = (state_r == S_POP) && out_free;
    out_load    = out_free &&
                  (((state_r == S_EXEC) && !((req_act_r == ACT_ALLOC) && sel_any)) ||
                   (state_r == S_POP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= LOWEST_RST;
      top_r    <= TOP_RST;
      base_r   <= BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOWEST: begin
          lowest_r <= cfg_data;
          base_r   <= ({1'b0, cfg_data} + (ADDR_W+1)'(PAGE_BYTES - 1)) & PAGE_MASK;
        end
        CFG_TOP: top_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_act_r  <= in_tuser;
            req_core_r <= core_fold(in_tdata[CORE_FW-1:0]);
            req_addr_r <= in_tdata[CORE_FW+ADDR_W-1:CORE_FW];
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_act_r == ACT_ALLOC && sel_any) begin
            state_r <= S_POP;
          end else if (out_free) begin
            out_addr_r   <= '0;
            if (req_act_r == ACT_FREE) begin
              out_status_r <= chk_bad ? ST_BAD_FREE : ST_OK;
            end else begin
              out_status_r <= ST_OOM;
            end
            state_r <= S_IDLE;
          end
        end
        S_POP: begin
          if (out_free) begin
            out_addr_r   <= pop_addr;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PCPA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready,
    "transaction accepted while a request is in progress")
  `PCPA_ASSERT_NOW(a_ram_one_port, clk, rst_n, ram_we, !ram_re && !hctl.pop,
    "link write collides with a pop")
  `PCPA_ASSERT_NOW(a_fail_no_addr, clk, rst_n, out_valid_r && out_status_r != ST_OK,
    out_addr_r == '0 && (out_status_r == ST_OOM || out_status_r == ST_BAD_FREE),
    "failed transaction carries an address or unknown status")

endmodule
`default_nettype wire

// ===== tb/tb_per_core_page_allocator_with_steal_unit.sv =====
`timescale 1ns / 1ps
module tb_per_core_page_allocator_with_steal_unit;
  import pcpa_pkg::*;

  localparam int CORES   = NUM_CORES_DEF;
  localparam int PAGES   = NUM_PAGES_DEF;
  localparam int PAGE_SZ = PAGE_BYTES_DEF;

  typedef struct {
    logic [ADDR_W-1:0]   page_addr;
    logic [STATUS_W-1:0] status;
  } page_result_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = ACT_ALLOC;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index   = CFG_LOWEST;
  logic [ADDR_W-1:0]      cfg_data    = '0;

  logic [ADDR_W-1:0] lowest_q = LOWEST_RST;
  logic [ADDR_W-1:0] top_q    = TOP_RST;
  int unsigned       core_head [CORES];
  int unsigned       page_link [PAGES];
  page_result_t      awaited_results [$];

  int items_sent    = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int send_idle_pct = 0;
  int out_stall_pct = 0;

  per_core_page_allocator_with_steal_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_per_core_page_allocator_with_steal_unit: FAIL");
    $finish;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic longint unsigned page_base();
    longint unsigned lo;
    lo = lowest_q;
    return ((lo + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
  endfunction

  function automatic int unsigned pop_core(int c);
    int unsigned h;
    h = core_head[c];
    if (h != 0) begin
      core_head[c] = page_link[h - 1];
      return h;
    end
    return 0;
  endfunction

  function automatic page_result_t serve_request(logic act, logic [CORE_FW-1:0] core,
                                                 logic [ADDR_W-1:0] addr);
    longint unsigned base;
    longint unsigned a;
    longint unsigned idx;
    bit              bad;
    int unsigned     got;
    page_result_t    r;
    base        = page_base();
    a           = addr;
    r.page_addr = '0;
    if (act == ACT_FREE) begin
      bad = (a % PAGE_SZ) != 0 || a < lowest_q || a >= top_q || a < base;
      idx = bad ? 0 : (a - base) / PAGE_SZ;
      if (!bad && idx >= PAGES) bad = 1'b1;
      if (bad) begin
        r.status = ST_BAD_FREE;
      end else begin
        page_link[idx]  = core_head[core];
        core_head[core] = int'(idx) + 1;
        r.status        = ST_OK;
      end
    end else begin
      got = pop_core(core);
      for (int c = 0; got == 0 && c < CORES; c++) begin
        if (c != core) got = pop_core(c);
      end
      if (got == 0) begin
        r.status = ST_OOM;
      end else begin
        r.page_addr = ADDR_W'(base + longint'(got - 1) * PAGE_SZ);
        r.status    = ST_OK;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t exp_r;
    out_tready <= ($urandom_range(99) >= out_stall_pct);
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOWEST) lowest_q = cfg_data;
        else top_q = cfg_data;
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(serve_request(in_tuser, in_tdata[2:0], in_tdata[34:3]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result: page_addr %h status %0d",
                                 out_tdata[31:0], out_tdata[33:32]));
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_tdata[31:0] !== exp_r.page_addr || out_tdata[33:32] !== exp_r.status)
            note_failure($sformatf(
              "mismatch: expected page_addr %h status %0d, got page_addr %h status %0d",
              exp_r.page_addr, exp_r.status, out_tdata[31:0], out_tdata[33:32]));
        end
      end
    end
  end

  task automatic send_req(logic act, logic [CORE_FW-1:0] core, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_TDATA_W'({addr, core});
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic set_regs(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOWEST;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TOP;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_page_addr();
    longint unsigned base;
    longint unsigned n;
    longint unsigned idx;
    longint unsigned hi;
    base = page_base();
    hi   = top_q;
    if (base >= hi) return $urandom;
    n = (hi - base + PAGE_SZ - 1) / PAGE_SZ;
    if (n > PAGES + 4) n = PAGES + 4;
    if ($urandom_range(1) == 0 && n > 64) idx = $urandom_range(63, 0);
    else idx = $urandom_range(int'(n - 1), 0);
    return ADDR_W'(base + idx * PAGE_SZ);
  endfunction

  task automatic test_alloc_steal();
    send_req(ACT_ALLOC, 3'd0, 32'h0000_0000);
    send_req(ACT_FREE,  3'd3, 32'h8000_0000);
    send_req(ACT_FREE,  3'd3, 32'h87FF_F000);
    send_req(ACT_FREE,  3'd7, 32'h8000_1000);
    send_req(ACT_ALLOC, 3'd3, 32'hFFFF_FFFF);
    send_req(ACT_ALLOC, 3'd0, 32'h0000_0000);
    send_req(ACT_ALLOC, 3'd5, 32'h0000_0000);
    send_req(ACT_ALLOC, 3'd7, 32'h0000_0000);
  endtask

  task automatic test_bad_free();
    send_req(ACT_FREE, 3'd1, 32'h8000_0001);
    send_req(ACT_FREE, 3'd1, 32'h7FFF_F000);
    send_req(ACT_FREE, 3'd1, 32'h8800_0000);
    send_req(ACT_FREE, 3'd1, 32'hFFFF_FFFF);
    send_req(ACT_FREE, 3'd1, 32'h0000_0000);
  endtask

  task automatic test_storage_limit();
    set_regs(32'h0000_0000, 32'hFFFF_FFFF);
    send_req(ACT_FREE, 3'd1, 32'h07FF_F000);
    send_req(ACT_FREE, 3'd1, 32'h0800_0000);
    send_req(ACT_FREE, 3'd2, 32'h0000_0000);
    send_req(ACT_FREE, 3'd0, 32'h0000_5000);
  endtask

  task automatic test_base_wrap();
    set_regs(32'hFFFF_F001, 32'hFFFF_FFFF);
    send_req(ACT_ALLOC, 3'd1, 32'h0000_0000);
    send_req(ACT_FREE,  3'd4, 32'hFFFF_F000);
    set_regs(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_req(ACT_ALLOC, 3'd0, 32'h0000_0000);
    send_req(ACT_FREE,  3'd4, 32'hFFFF_F000);
    send_req(ACT_ALLOC, 3'd4, 32'h0000_0000);
    set_regs(32'hFFFF_FFFF, 32'h0000_0000);
    send_req(ACT_FREE,  3'd6, 32'h0000_0000);
    send_req(ACT_ALLOC, 3'd6, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    int                idle_pct [4] = '{0, 60, 0, 21};
    int                stall_pct [4] = '{0, 0, 60, 21};
    int                alloc_pct;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pct[p];
      out_stall_pct = stall_pct[p];
      for (int b = 0; b < 3; b++) begin
        case ($urandom_range(5))
          0: begin
            lo = LOWEST_RST;
            hi = TOP_RST;
          end
          1: begin
            lo = 32'h0000_0000;
            hi = 32'hFFFF_FFFF;
          end
          2: begin
            lo = $urandom & 32'hFFFF_F000;
            hi = lo + $urandom_range(40000, 16) * PAGE_SZ;
          end
          3: begin
            lo = $urandom;
            hi = lo + $urandom_range(32'h1000_0000, 32'h0010_0000);
          end
          4: begin
            lo = $urandom;
            hi = $urandom;
          end
          default: begin
            lo = 32'hFFFF_FFFF;
            hi = 32'h0000_0000;
          end
        endcase
        set_regs(lo, hi);
        alloc_pct = $urandom_range(65, 30);
        repeat (130) begin
          if ($urandom_range(99) < alloc_pct)
            send_req(ACT_ALLOC, CORE_FW'($urandom_range(CORES - 1)), $urandom);
          else if ($urandom_range(99) < 85)
            send_req(ACT_FREE, CORE_FW'($urandom_range(CORES - 1)), pick_page_addr());
          else
            send_req(ACT_FREE, CORE_FW'($urandom_range(CORES - 1)), $urandom);
        end
      end
    end
    send_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_alloc_steal();
    test_bad_free();
    test_storage_limit();
    test_base_wrap();
    test_random_traffic();
    wait_all_results();
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    if (fail_count == 0) begin
      $display("tb_per_core_page_allocator_with_steal_unit: PASS");
    end else begin
      $display("tb_per_core_page_allocator_with_steal_unit: FAIL");
    end
    $finish;
  end

endmodule
